// ===== hdl/orl_pkg.sv =====
package orl_pkg;

	// Width of a position or a length inside the block. It covers every list depth up
	// to 256 entries, and an append position that equals the depth.
	localparam int POS_W = 9;
	localparam int CODE_W = 32;

	// Stream payload widths (fields packed from bit 0 up, tdata padded to whole bytes).
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 48;

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_ERASE  = 3'd2,
		OP_READ   = 3'd3,
		OP_FIND   = 3'd4,
		OP_UPDATE = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// What every cell does at a clock edge.
	typedef enum logic [1:0] {
		ACT_HOLD   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_ERASE  = 2'd2,
		ACT_UPDATE = 2'd3
	} cell_act_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} fsm_t;

	typedef struct packed {
		logic               healthy;
		logic               sex;
		logic signed [31:0] code;
	} rec_t;

	// Command broadcast along the row of cells.
	typedef struct packed {
		cell_act_t          act;
		logic [POS_W-1:0]   pos;
		rec_t               rec;
		logic               match_en;
	} cell_ctl_t;

endpackage

// ===== hdl/ordered_record_list.sv =====
// Channel   Direction  Signals                           Payload, lowest bit first
// --------  ---------  --------------------------------  --------------------------------------
// s (cmd)   in         s_tvalid s_tready s_tdata s_tuser tdata: position, code, sex_bit, healthy
//                                                        tuser: op
// m (resp)  out        m_tvalid m_tready m_tdata         tdata: status, found_position,
//                                                        found_code, found_sex, found_healthy,
//                                                        list_length
//
// A command is handled at the accepting edge, at which every cell compares its code
// with the incoming key, and then at an execute edge, at which the whole row of cells
// shifts, loads or overwrites in a single step and the response register is loaded.
// The execute step holds the priority pick of the first match and the record select
// across the row. No further command is taken until after that edge.
// Reset clears the sequencer state, the list length and the response valid flag only.
// The record cells are not cleared; no cell at or beyond the length is ever reported,
// so no clearing pass is needed and the block is ready as soon as reset is released.
// A stalled response holds the execute step: the row is only changed in the cycle that
// the response register is written, so a waiting response always reports the length
// that the row holds. One response may wait while the next command is taken.
module ordered_record_list #(
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// position [4:0], code [36:5], sex_bit [37], healthy [38], zero pad [39]
	input  logic [orl_pkg::S_TDATA_W-1:0]   s_tdata,
	// op [2:0]
	input  logic [orl_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status [1:0], found_position [5:2], found_code [37:6], found_sex [38],
	// found_healthy [39], list_length [44:40], zero pad [47:45]
	output logic [orl_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = orl_pkg::POS_W;

	orl_pkg::fsm_t      state_q;
	orl_pkg::fsm_t      state_d;
	orl_pkg::op_t       op_q;
	logic [4:0]         pos_q;
	orl_pkg::rec_t      rec_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;

	// Response register.
	logic               m_tvalid_q;
	orl_pkg::status_t   status_q;
	logic [3:0]         rpos_q;
	orl_pkg::rec_t      rrec_q;
	logic [4:0]         rlen_q;

	// Row of cells.
	orl_pkg::cell_ctl_t ctl;
	orl_pkg::rec_t      entry_v [DEPTH];
	logic [DEPTH-1:0]   match_v;

	// Execute-step decode.
	logic [PW-1:0]      pos9;
	logic [PW-1:0]      cnt9;
	logic               full;
	logic               hit;
	logic [IW-1:0]      sel_idx;
	orl_pkg::rec_t      sel_rec;
	orl_pkg::status_t   res_status;
	logic [PW-1:0]      res_pos;
	orl_pkg::rec_t      res_rec;
	logic               res_has;
	orl_pkg::cell_act_t res_act;
	logic [CW-1:0]      res_count;
	logic               out_load;
	logic               accept;

	assign accept = s_tvalid && s_tready;
	assign pos9   = PW'(pos_q);
	assign cnt9   = PW'(count_q);
	assign full   = (count_q == CW'(DEPTH));

	generate
		for (genvar g = 0; g < DEPTH; g++) begin : g_cell
			orl_pkg::rec_t prev_rec;
			orl_pkg::rec_t next_rec;

			if (g == 0) begin : g_first
				assign prev_rec = entry_v[g];
			end else begin : g_prev
				assign prev_rec = entry_v[g-1];
			end

			// The last cell has no neighbor behind it; what it keeps on an erase lies
			// beyond the new length and is never reported.
			if (g == DEPTH - 1) begin : g_last
				assign next_rec = entry_v[g];
			end else begin : g_next
				assign next_rec = entry_v[g+1];
			end

			orl_cell #(
				.INDEX(g)
			) u_cell (
				.clk  (clk),
				.ctl  (ctl),
				.prev (prev_rec),
				.next (next_rec),
				.entry(entry_v[g]),
				.match(match_v[g])
			);
		end
	endgenerate

	orl_select #(
		.DEPTH(DEPTH)
	) u_select (
		.entries(entry_v),
		.match  (match_v),
		.count  (count_q),
		.pos_idx(pos9[IW-1:0]),
		.use_hit(op_q == orl_pkg::OP_FIND),
		.hit    (hit),
		.sel_idx(sel_idx),
		.sel_rec(sel_rec)
	);

	// Result of the held command against the current list.
	always_comb begin
		res_status = orl_pkg::ST_OK;
		res_pos    = '0;
		res_rec    = '0;
		res_has    = 1'b0;
		res_act    = orl_pkg::ACT_HOLD;
		res_count  = count_q;
		case (op_q)
			orl_pkg::OP_APPEND: begin
				if (full) begin
					res_status = orl_pkg::ST_FULL;
				end else begin
					// An append is an insert at the tail.
					res_act   = orl_pkg::ACT_INSERT;
					res_pos   = cnt9;
					res_rec   = rec_q;
					res_has   = 1'b1;
					res_count = count_q + CW'(1);
				end
			end
			orl_pkg::OP_INSERT: begin
				if (pos9 > cnt9) begin
					res_status = orl_pkg::ST_BADPOS;
				end else if (full) begin
					res_status = orl_pkg::ST_FULL;
				end else begin
					res_act   = orl_pkg::ACT_INSERT;
					res_pos   = pos9;
					res_rec   = rec_q;
					res_has   = 1'b1;
					res_count = count_q + CW'(1);
				end
			end
			orl_pkg::OP_ERASE: begin
				if (pos9 >= cnt9) begin
					res_status = orl_pkg::ST_BADPOS;
				end else begin
					res_act   = orl_pkg::ACT_ERASE;
					res_pos   = pos9;
					res_rec   = sel_rec;
					res_has   = 1'b1;
					res_count = count_q - CW'(1);
				end
			end
			orl_pkg::OP_READ: begin
				if (pos9 >= cnt9) begin
					res_status = orl_pkg::ST_BADPOS;
				end else begin
					res_pos = pos9;
					res_rec = sel_rec;
					res_has = 1'b1;
				end
			end
			orl_pkg::OP_FIND: begin
				if (hit) begin
					res_pos = PW'(sel_idx);
					res_rec = sel_rec;
					res_has = 1'b1;
				end else begin
					res_status = orl_pkg::ST_NOTFOUND;
				end
			end
			orl_pkg::OP_UPDATE: begin
				if (pos9 >= cnt9) begin
					res_status = orl_pkg::ST_BADPOS;
				end else begin
					res_act         = orl_pkg::ACT_UPDATE;
					res_pos         = pos9;
					res_rec.code    = sel_rec.code;
					res_rec.sex     = rec_q.sex;
					res_rec.healthy = rec_q.healthy;
					res_has         = 1'b1;
				end
			end
			default: begin
				// Unused op codes change nothing and report an empty record.
				res_status = orl_pkg::ST_OK;
			end
		endcase
		if (!res_has) begin
			res_pos = '0;
			res_rec = '0;
		end
	end

	// Sequencer: next state, handshake and the command for the row of cells.
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		out_load     = 1'b0;
		count_d      = count_q;
		ctl.act      = orl_pkg::ACT_HOLD;
		ctl.pos      = res_pos;
		ctl.rec      = rec_q;
		ctl.match_en = 1'b0;
		case (state_q)
			orl_pkg::S_IDLE: begin
				s_tready = 1'b1;
				// Every cell compares its code with the incoming key at the accepting edge.
				ctl.match_en = 1'b1;
				ctl.rec.code = s_tdata[36:5];
				if (s_tvalid) begin
					state_d = orl_pkg::S_EXEC;
				end
			end
			orl_pkg::S_EXEC: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					ctl.act  = res_act;
					count_d  = res_count;
					state_d  = orl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = orl_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= orl_pkg::S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= orl_pkg::op_t'(s_tuser);
			pos_q       <= s_tdata[4:0];
			rec_q.code  <= s_tdata[36:5];
			rec_q.sex   <= s_tdata[37];
			rec_q.healthy <= s_tdata[38];
		end
		if (out_load) begin
			status_q <= res_status;
			rpos_q   <= res_pos[3:0];
			rrec_q   <= res_rec;
			rlen_q   <= 5'(res_count);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, rlen_q, rrec_q.healthy, rrec_q.sex, rrec_q.code,
		rpos_q, status_q};

	// The list never grows past its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("list length beyond depth");

	// The length only moves at the execute edge that also loads a response.
	a_count_moves_with_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != count_d) |-> out_load)
		else $error("list length changed without a response");

	// A full response is only given while the list holds its depth.
	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && status_q == orl_pkg::ST_FULL) |-> (count_q == CW'(DEPTH)))
		else $error("full reported on a list with room");

	// A waiting response reports the length that the row holds.
	a_len_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (rlen_q == 5'(count_q)))
		else $error("response length differs from list length");

	// A command is taken only in the idle step and always followed by an execute step.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == orl_pkg::S_EXEC))
		else $error("accepted command not executed");

endmodule

// ===== hdl/orl_cell.sv =====
module orl_cell #(
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  orl_pkg::cell_ctl_t ctl,
	input  orl_pkg::rec_t     prev,
	input  orl_pkg::rec_t     next,
	output orl_pkg::rec_t     entry,
	output logic              match
);

	localparam logic [orl_pkg::POS_W-1:0] IDX = orl_pkg::POS_W'(INDEX);

	orl_pkg::rec_t entry_q;
	orl_pkg::rec_t entry_d;
	logic          match_q;
	logic          match_d;

	// Each cell decides from its own place in the row whether it takes the new record,
	// its neighbor's record or keeps its own; on an update it takes only the new sex and healthy bits.
	always_comb begin
		entry_d = entry_q;
		case (ctl.act)
			orl_pkg::ACT_INSERT: begin
				if (IDX > ctl.pos) begin
					entry_d = prev;
				end else if (IDX == ctl.pos) begin
					entry_d = ctl.rec;
				end
			end
			orl_pkg::ACT_ERASE: begin
				if (IDX >= ctl.pos) begin
					entry_d = next;
				end
			end
			orl_pkg::ACT_UPDATE: begin
				if (IDX == ctl.pos) begin
					entry_d.sex     = ctl.rec.sex;
					entry_d.healthy = ctl.rec.healthy;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
		match_d = ctl.match_en ? (entry_q.code == ctl.rec.code) : match_q;
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
		match_q <= match_d;
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// ===== hdl/orl_select.sv =====
module orl_select #(
	parameter int DEPTH = 16
) (
	input  orl_pkg::rec_t           entries [DEPTH],
	input  logic [DEPTH-1:0]        match,
	input  logic [$clog2(DEPTH+1)-1:0] count,
	input  logic [$clog2(DEPTH)-1:0] pos_idx,
	input  logic                    use_hit,
	output logic                    hit,
	output logic [$clog2(DEPTH)-1:0] sel_idx,
	output orl_pkg::rec_t           sel_rec
);

	localparam int IW = $clog2(DEPTH);

	logic [IW-1:0] hit_idx;

	// Lowest matching cell below the list length wins.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i] && (i < int'(count))) begin
				hit     = 1'b1;
				hit_idx = IW'(i);
			end
		end
	end

	assign sel_idx = use_hit ? hit_idx : pos_idx;
	assign sel_rec = entries[sel_idx];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int LIST_DEPTH = 16;

	// Op codes 6 and 7 are not operations; the block must answer them with an empty record.
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	// One response as the list should report it.
	typedef struct packed {
		orl_pkg::status_t status;
		logic [3:0]       pos;
		orl_pkg::rec_t    rec;
		logic [4:0]       len;
	} reply_t;

	// Shadow copy of the record list. Commands are applied in the order they were
	// transferred, and the response each one should give is queued until it arrives.
	class record_list_scoreboard;
		orl_pkg::rec_t entries[LIST_DEPTH];
		int unsigned   count;
		reply_t        replies_due[$];
		int unsigned   mismatches;

		function new();
			count = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		function void note_command(logic [2:0] op, logic [4:0] pos, logic [31:0] code,
				logic sex, logic hl);
			reply_t        r;
			orl_pkg::rec_t nr;
			int            i;
			r = '0;
			nr.code = code;
			nr.sex = sex;
			nr.healthy = hl;
			case (op)
				orl_pkg::OP_APPEND: begin
					if (count >= LIST_DEPTH) begin
						r.status = orl_pkg::ST_FULL;
					end else begin
						entries[count] = nr;
						r.pos = count[3:0];
						r.rec = nr;
						count++;
					end
				end
				orl_pkg::OP_INSERT: begin
					// An out-of-range position wins over a full list.
					if (pos > count) begin
						r.status = orl_pkg::ST_BADPOS;
					end else if (count >= LIST_DEPTH) begin
						r.status = orl_pkg::ST_FULL;
					end else begin
						for (i = count; i > pos; i--)
							entries[i] = entries[i - 1];
						entries[pos] = nr;
						r.pos = pos[3:0];
						r.rec = nr;
						count++;
					end
				end
				orl_pkg::OP_ERASE: begin
					if (pos >= count) begin
						r.status = orl_pkg::ST_BADPOS;
					end else begin
						r.pos = pos[3:0];
						r.rec = entries[pos];
						for (i = pos; i + 1 < count; i++)
							entries[i] = entries[i + 1];
						count--;
					end
				end
				orl_pkg::OP_READ: begin
					if (pos >= count) begin
						r.status = orl_pkg::ST_BADPOS;
					end else begin
						r.pos = pos[3:0];
						r.rec = entries[pos];
					end
				end
				orl_pkg::OP_FIND: begin
					r.status = orl_pkg::ST_NOTFOUND;
					for (i = 0; i < count; i++) begin
						if (r.status == orl_pkg::ST_NOTFOUND && entries[i].code == code) begin
							r.status = orl_pkg::ST_OK;
							r.pos = i[3:0];
							r.rec = entries[i];
						end
					end
				end
				orl_pkg::OP_UPDATE: begin
					if (pos >= count) begin
						r.status = orl_pkg::ST_BADPOS;
					end else begin
						entries[pos].sex = sex;
						entries[pos].healthy = hl;
						r.pos = pos[3:0];
						r.rec = entries[pos];
					end
				end
				default: ;
			endcase
			r.len = count[4:0];
			replies_due.push_back(r);
		endfunction

		task report_mismatch(string what);
			$display("%0t ns: mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task check_response(logic [47:0] data);
			reply_t want;
			reply_t got;
			got.status = orl_pkg::status_t'(data[1:0]);
			got.pos = data[5:2];
			got.rec.code = data[37:6];
			got.rec.sex = data[38];
			got.rec.healthy = data[39];
			got.len = data[44:40];
			if (replies_due.size() == 0) begin
				report_mismatch("response with no command outstanding");
			end else begin
				want = replies_due.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.pos !== want.pos)
					report_mismatch($sformatf("found_position %0d, want %0d", got.pos, want.pos));
				if (got.rec.code !== want.rec.code)
					report_mismatch($sformatf("found_code %h, want %h",
						got.rec.code, want.rec.code));
				if (got.rec.sex !== want.rec.sex)
					report_mismatch($sformatf("found_sex %b, want %b",
						got.rec.sex, want.rec.sex));
				if (got.rec.healthy !== want.rec.healthy)
					report_mismatch($sformatf("found_healthy %b, want %b",
						got.rec.healthy, want.rec.healthy));
				if (got.len !== want.len)
					report_mismatch($sformatf("list_length %0d, want %0d", got.len, want.len));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// position [4:0], code [36:5], sex_bit [37], healthy [38], zero pad [39]
	logic [39:0] s_tdata = '0;
	// op [2:0]
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// status [1:0], found_position [5:2], found_code [37:6], found_sex [38],
	// found_healthy [39], list_length [44:40], zero pad [47:45]
	logic [47:0] m_tdata;

	record_list_scoreboard board;

	// Percent chance, per cycle, that the command side holds back or the response
	// side refuses a transfer. The main sequence changes them from phase to phase.
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;

	// Random traffic alternates between filling the list and draining it, so that
	// both the full and the empty list are visited many times.
	bit          growing = 1'b1;
	logic [31:0] code_pool[8];

	ordered_record_list #(.DEPTH(LIST_DEPTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #4 clk = ~clk;

	// The response side decides afresh every cycle whether it will take a transfer.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Inputs change only at rising edges, so the values seen at the falling edge are the
	// ones the next rising edge will act on. The response is checked before the command
	// is noted: a response in the same cycle always belongs to an older command.
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_response(m_tdata);
			if (s_tvalid && s_tready)
				board.note_command(s_tuser, s_tdata[4:0], s_tdata[36:5], s_tdata[37],
					s_tdata[38]);
		end
	end

	// Offers one command and returns right after the edge that transferred it.
	task automatic send_command(logic [2:0] op, logic [4:0] pos, logic [31:0] code,
			logic sex, logic hl);
		bit taken;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, hl, sex, code, pos};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Holds the command side quiet until every response has come back.
	task automatic drain_responses();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Keys are often taken from a small pool so that duplicates and find hits are common.
	function automatic logic [31:0] pick_code();
		if ($urandom_range(0, 9) < 4)
			return code_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	task automatic random_command();
		int unsigned pick;
		int unsigned len;
		logic [2:0]  op;
		logic [4:0]  pos;
		logic [31:0] key;
		len = board.count;
		if (len == LIST_DEPTH && $urandom_range(0, 3) == 0)
			growing = 1'b0;
		else if (len == 0)
			growing = 1'b1;
		else if ($urandom_range(0, 59) == 0)
			growing = !growing;
		pick = $urandom_range(0, 99);
		if (growing) begin
			if (pick < 28) op = orl_pkg::OP_APPEND;
			else if (pick < 56) op = orl_pkg::OP_INSERT;
			else if (pick < 64) op = orl_pkg::OP_ERASE;
			else if (pick < 74) op = orl_pkg::OP_READ;
			else if (pick < 86) op = orl_pkg::OP_FIND;
			else if (pick < 97) op = orl_pkg::OP_UPDATE;
			else op = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
		end else begin
			if (pick < 8) op = orl_pkg::OP_APPEND;
			else if (pick < 16) op = orl_pkg::OP_INSERT;
			else if (pick < 56) op = orl_pkg::OP_ERASE;
			else if (pick < 68) op = orl_pkg::OP_READ;
			else if (pick < 82) op = orl_pkg::OP_FIND;
			else if (pick < 96) op = orl_pkg::OP_UPDATE;
			else op = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
		end
		// Mostly legal positions, with a share across the whole five-bit range.
		if ($urandom_range(0, 4) == 0)
			pos = 5'($urandom_range(0, 31));
		else if (op == orl_pkg::OP_INSERT)
			pos = 5'($urandom_range(0, len));
		else if (len > 0)
			pos = 5'($urandom_range(0, len - 1));
		else
			pos = '0;
		if (op == orl_pkg::OP_FIND && len > 0 && $urandom_range(0, 1) == 1)
			key = board.entries[$urandom_range(0, len - 1)].code;
		else
			key = pick_code();
		send_command(op, pos, key, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		board = new();
		code_pool[0] = 32'h0000_0000;
		code_pool[1] = 32'hFFFF_FFFF;
		code_pool[2] = 32'h8000_0000;
		code_pool[3] = 32'h7FFF_FFFF;
		for (int k = 4; k < 8; k++)
			code_pool[k] = $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// On the empty list every positioned op is out of range and a find misses.
		send_command(orl_pkg::OP_READ, 5'd0, 32'h0, 1'b0, 1'b0);
		send_command(orl_pkg::OP_ERASE, 5'd0, 32'h0, 1'b0, 1'b0);
		send_command(orl_pkg::OP_UPDATE, 5'd0, 32'h0, 1'b1, 1'b1);
		send_command(orl_pkg::OP_FIND, 5'd0, 32'h0, 1'b0, 1'b0);
		send_command(orl_pkg::OP_INSERT, 5'd1, 32'h1234_5678, 1'b0, 1'b0);
		// Insert at the front twice: the first entry has to survive behind the new one.
		send_command(orl_pkg::OP_INSERT, 5'd0, 32'h8000_0000, 1'b0, 1'b0);
		send_command(orl_pkg::OP_INSERT, 5'd0, 32'h7FFF_FFFF, 1'b1, 1'b1);
		// The position of an append is ignored, even with its top bit set.
		send_command(orl_pkg::OP_APPEND, 5'd31, 32'hFFFF_FFFF, 1'b1, 1'b0);
		// Insert at the tail with a duplicate key, then in the middle.
		send_command(orl_pkg::OP_INSERT, 5'd3, 32'h8000_0000, 1'b0, 1'b1);
		send_command(orl_pkg::OP_INSERT, 5'd1, 32'h0000_0000, 1'b1, 1'b0);
		// The duplicate key must be found at its first position.
		send_command(orl_pkg::OP_FIND, 5'd0, 32'h8000_0000, 1'b0, 1'b0);
		send_command(orl_pkg::OP_READ, 5'd31, 32'h0, 1'b0, 1'b0);
		send_command(orl_pkg::OP_READ, 5'd4, 32'h0, 1'b0, 1'b0);
		send_command(orl_pkg::OP_UPDATE, 5'd2, 32'h0, 1'b1, 1'b1);
		send_command(orl_pkg::OP_ERASE, 5'd1, 32'h0, 1'b0, 1'b0);
		send_command(orl_pkg::OP_ERASE, 5'd3, 32'h0, 1'b0, 1'b0);
		send_command(OP_SPARE_6, 5'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_command(OP_SPARE_7, 5'd2, 32'h0, 1'b0, 1'b0);
		// Fill the list, then hit it with a full append, a full insert, and an insert
		// whose position is bad as well as full.
		while (board.count < LIST_DEPTH)
			send_command(orl_pkg::OP_APPEND, 5'($urandom_range(0, 31)), $urandom,
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		send_command(orl_pkg::OP_APPEND, 5'd0, 32'h5555_AAAA, 1'b1, 1'b1);
		send_command(orl_pkg::OP_INSERT, 5'd16, 32'hAAAA_5555, 1'b0, 1'b1);
		send_command(orl_pkg::OP_INSERT, 5'd17, 32'hAAAA_5555, 1'b1, 1'b0);
		send_command(orl_pkg::OP_READ, 5'd15, 32'h0, 1'b0, 1'b0);

		// Random traffic in four idling phases: none, slow sender, slow receiver, both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 68; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 68; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase
			// Let the list settle completely once, mid run.
			if (phase == 2)
				drain_responses();
			for (int n = 0; n < 375; n++)
				random_command();
		end

		drain_responses();
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
